// ===== hdl/fsrf_pkg.sv =====
// Package for the frame slot ring FIFO: sizes, codes, command struct and helpers.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package fsrf_pkg;

    // Ring geometry
    localparam int SLOTS      = 64;
    localparam int SLOT_BYTES = 2048;

    localparam int SLOT_W = $clog2(SLOTS);           // slot index
    localparam int BYTE_W = $clog2(SLOT_BYTES);      // byte index inside a slot
    localparam int OFF_W  = $clog2(SLOT_BYTES + 1);  // offset / length, holds SLOT_BYTES
    localparam int CNT_W  = $clog2(SLOTS + 1);       // held frame count, holds SLOTS
    localparam int ADDR_W = SLOT_W + BYTE_W;         // byte store address
    localparam int DEPTH  = SLOTS * SLOT_BYTES;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int DATA_W   = 8;
    localparam int STATUS_W = 2;
    localparam int SCOUNT_W = 7;
    localparam int MAXLEN_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Register reset values
    localparam logic [SCOUNT_W-1:0] SLOT_COUNT_RST = 7'd50;
    localparam logic [MAXLEN_W-1:0] MAX_FRAME_RST  = 12'd2048;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME  = 2'd1;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_TOO_LONG = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the accepted input word
        logic exec;   // apply the item and load the result register
    } fsrf_cmd_t;

    // Advance a slot index, wrapping at the number of slots in use
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                    input logic [CNT_W-1:0]  used);
        logic [SLOT_W:0] t;
        t = {1'b0, s} + 1'b1;
        if (32'(t) >= 32'(used))
            return '0;
        else
            return t[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/fsrf_ctrl.sv =====
// Controller of the frame slot ring FIFO: sequences accept and execute, owns result valid.
// Depends on fsrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fsrf_ctrl
    import fsrf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    output fsrf_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   exec_go;

    // Execute only once the result register is free or being emptied
    assign exec_go  = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_go)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_go)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign cmd.load  = in_valid && (state_reg == ST_IDLE);
    assign cmd.exec  = exec_go;

endmodule

`default_nettype wire

// ===== hdl/fsrf_datapath.sv =====
// Datapath of the frame slot ring FIFO: ring indices, byte store, length table, result register.
// Depends on fsrf_pkg; driven by fsrf_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module fsrf_datapath
    import fsrf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire fsrf_cmd_t             cmd,
    input  wire logic [KIND_W-1:0]     in_kind,
    input  wire logic [DATA_W-1:0]     in_byte,
    input  wire logic                  in_last,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic [STATUS_W-1:0]        out_status,
    output logic [DATA_W-1:0]          out_byte,
    output logic                       out_last,
    output logic [SCOUNT_W-1:0]        out_count
);

    // Memories (no reset: contents undefined until written)
    logic [DATA_W-1:0] byte_mem [DEPTH];
    logic [OFF_W-1:0]  len_mem  [SLOTS];
    logic [DATA_W-1:0] rd_byte_reg;
    logic [OFF_W-1:0]  rd_len_reg;

    // Configuration
    logic [SCOUNT_W-1:0] slot_count_reg;
    logic [MAXLEN_W-1:0] max_frame_reg;
    logic [CNT_W-1:0]    used_slots;
    logic [OFF_W-1:0]    frame_limit;

    // Ring state
    logic [SLOT_W-1:0] wslot_reg, wslot_next;
    logic [SLOT_W-1:0] rslot_reg, rslot_next;
    logic [CNT_W-1:0]  held_reg,  held_next;
    logic [OFF_W-1:0]  woff_reg,  woff_next;
    logic [OFF_W-1:0]  roff_reg,  roff_next;
    logic              too_long_reg, too_long_next;
    logic              blocked_reg,  blocked_next;

    // Captured input word
    logic [KIND_W-1:0] kind_reg;
    logic [DATA_W-1:0] byte_reg;
    logic              last_reg;

    // Result register
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0]   obyte_reg,  obyte_next;
    logic                olast_reg,  olast_next;

    logic              byte_we, len_we, full;
    logic [OFF_W-1:0]  woff_inc;
    logic [OFF_W:0]    roff_inc;

    always_comb
    begin
        if (slot_count_reg == '0)
            used_slots = CNT_W'(1);
        else if (32'(slot_count_reg) > SLOTS)
            used_slots = CNT_W'(SLOTS);
        else
            used_slots = CNT_W'(slot_count_reg);
        if (32'(max_frame_reg) > SLOT_BYTES)
            frame_limit = OFF_W'(SLOT_BYTES);
        else
            frame_limit = OFF_W'(max_frame_reg);
    end

    assign full     = (32'(held_reg) >= 32'(used_slots));
    assign woff_inc = woff_reg + 1'b1;
    assign roff_inc = {1'b0, roff_reg} + 1'b1;

    always_comb
    begin
        wslot_next    = wslot_reg;
        rslot_next    = rslot_reg;
        held_next     = held_reg;
        woff_next     = woff_reg;
        roff_next     = roff_reg;
        too_long_next = too_long_reg;
        blocked_next  = blocked_reg;
        status_next   = STAT_OK;
        obyte_next    = '0;
        olast_next    = 1'b0;
        byte_we       = 1'b0;
        len_we        = 1'b0;
        case (kind_reg)
            KIND_WRITE:
            begin
                if (woff_reg >= frame_limit)
                    too_long_next = 1'b1;
                else
                begin
                    if (full)
                        blocked_next = 1'b1;
                    else
                        byte_we = 1'b1;
                    woff_next = woff_inc;
                end
                if (last_reg)
                begin
                    if (full || blocked_next)
                        status_next = STAT_FULL;
                    else if (too_long_next)
                        status_next = STAT_TOO_LONG;
                    else
                    begin
                        len_we     = 1'b1;
                        wslot_next = next_slot(wslot_reg, used_slots);
                        held_next  = held_reg + 1'b1;
                    end
                    woff_next     = '0;
                    too_long_next = 1'b0;
                    blocked_next  = 1'b0;
                end
            end
            KIND_READ:
            begin
                if (held_reg == '0)
                    status_next = STAT_EMPTY;
                else
                begin
                    obyte_next = rd_byte_reg;
                    if (roff_inc >= {1'b0, rd_len_reg})
                    begin
                        olast_next = 1'b1;
                        roff_next  = '0;
                        rslot_next = next_slot(rslot_reg, used_slots);
                        held_next  = held_reg - 1'b1;
                    end
                    else
                        roff_next = roff_inc[OFF_W-1:0];
                end
            end
            KIND_FLUSH:
            begin
                wslot_next    = '0;
                rslot_next    = '0;
                held_next     = '0;
                woff_next     = '0;
                roff_next     = '0;
                too_long_next = 1'b0;
                blocked_next  = 1'b0;
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
    end

    // Byte store: one write, one registered read at the head of the oldest frame
    always_ff @(posedge clk)
    begin
        if (cmd.exec && byte_we)
            byte_mem[{wslot_reg, woff_reg[BYTE_W-1:0]}] <= byte_reg;
        rd_byte_reg <= byte_mem[{rslot_reg, roff_reg[BYTE_W-1:0]}];
    end

    // Length table
    always_ff @(posedge clk)
    begin
        if (cmd.exec && len_we)
            len_mem[wslot_reg] <= woff_inc;
        rd_len_reg <= len_mem[rslot_reg];
    end

    // Input capture and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= in_kind;
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            obyte_reg  <= obyte_next;
            olast_reg  <= olast_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= SLOT_COUNT_RST;
            max_frame_reg  <= MAX_FRAME_RST;
            wslot_reg      <= '0;
            rslot_reg      <= '0;
            held_reg       <= '0;
            woff_reg       <= '0;
            roff_reg       <= '0;
            too_long_reg   <= 1'b0;
            blocked_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_idx == CFG_SLOT_COUNT))
                slot_count_reg <= cfg_wdata[SCOUNT_W-1:0];
            if (cfg_we && (cfg_idx == CFG_MAX_FRAME))
                max_frame_reg <= cfg_wdata[MAXLEN_W-1:0];
            if (cmd.exec)
            begin
                wslot_reg    <= wslot_next;
                rslot_reg    <= rslot_next;
                held_reg     <= held_next;
                woff_reg     <= woff_next;
                roff_reg     <= roff_next;
                too_long_reg <= too_long_next;
                blocked_reg  <= blocked_next;
            end
        end
    end

    assign out_status = status_reg;
    assign out_byte   = obyte_reg;
    assign out_last   = olast_reg;
    // Count register already reflects the item held in the result register
    assign out_count  = SCOUNT_W'(held_reg);

endmodule

`default_nettype wire

// ===== hdl/frame_slot_ring_fifo_top.sv =====
// Top level of the frame slot ring FIFO: stream ports, config port, controller and datapath.
// Depends on fsrf_pkg, fsrf_ctrl and fsrf_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Channel    Handshake                 Payload
// --------   -----------------------   -------------------------------------------------
// input      s_tvalid / s_tready       s_tdata wr_byte, s_tlast wr_last, s_tuser kind
// result     m_tvalid / m_tready       m_tdata rd_byte, frame_count; m_tlast rd_last;
//                                      m_tuser status
// config     cfg_valid / cfg_ready     cfg_index register index, cfg_data write data
//
// Each word is handled in an accept step, while the byte store and the length
// table deliver their registered read at the oldest frame, and then an execute step,
// which updates the ring and loads the result register. A stalled result holds the
// execute step; the next word is accepted while the previous result waits.
// Reset clears the ring indices, count and flags; the stores are not cleared, and
// config defaults to 50 slots and 2048-byte frames. cfg_ready is always high.

module frame_slot_ring_fifo_top
    import fsrf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] wr_byte
    input  wire logic                  s_tlast,   // wr_last
    input  wire logic [1:0]            s_tuser,   // [1:0] kind
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [15:0]                m_tdata,   // [7:0] rd_byte, [14:8] frame_count
    output logic                       m_tlast,   // rd_last
    output logic [1:0]                 m_tuser,   // [1:0] status
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    fsrf_cmd_t           cmd;
    logic [SCOUNT_W-1:0] frame_count;
    logic [DATA_W-1:0]   rd_byte;

    // The user must write config only while idle; the block does not enforce it: take it at once
    assign cfg_ready = 1'b1;

    fsrf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    fsrf_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_kind    (s_tuser),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .cfg_we     (cfg_valid),
        .cfg_idx    (cfg_index),
        .cfg_wdata  (cfg_data),
        .out_status (m_tuser),
        .out_byte   (rd_byte),
        .out_last   (m_tlast),
        .out_count  (frame_count)
    );

    // Pack result: byte low, count above, pad to whole bytes
    assign m_tdata = {1'b0, frame_count, rd_byte};

endmodule

`default_nettype wire

// ===== tb/tb_frame_slot_ring_fifo_top.sv =====
// Self-checking testbench for the frame slot ring FIFO: directed frames, then random phases.
// Depends on fsrf_pkg and frame_slot_ring_fifo_top; a scoreboard class predicts each result.
`timescale 1ns / 1ps
`default_nettype none

module tb_frame_slot_ring_fifo_top;
    import fsrf_pkg::*;

    localparam int CLK_HIGH     = 6;
    localparam int CLK_LOW      = 6;
    localparam int MAX_GAP      = 16;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int PHASE_WORDS  = 85;
    localparam int PHASES       = 9;
    localparam int LONG_FRAME   = 160;

    // kind code the block leaves unused
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    // slot_count and max_frame_bytes per random phase; -1 draws a random value
    int slot_plan [PHASES] = '{2, 0, 127, 1, 3, 64, 5, -1, -1};
    int limit_plan [PHASES] = '{6, 3, 16, 1, 0, 2048, 4095, -1, -1};

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   rd_byte;
        logic                rd_last;
        logic [CNT_W-1:0]    frame_count;
    } ring_result_t;

    // Predicts the result of every accepted word and checks the result stream.
    class frame_ring_scoreboard;
        bit [DATA_W-1:0]     byte_store [DEPTH];
        int unsigned         frame_len [SLOTS];
        bit                  len_written [SLOTS];
        int unsigned         wr_slot, rd_slot, held, wr_off, rd_off;
        bit                  too_long, blocked;
        logic [SCOUNT_W-1:0] slot_count;
        logic [MAXLEN_W-1:0] max_frame;
        ring_result_t        pending_results [$];
        int                  errors;

        function new();
            clear_ring();
            slot_count = SLOT_COUNT_RST;
            max_frame  = MAX_FRAME_RST;
            errors     = 0;
        endfunction

        function void clear_ring();
            wr_slot  = 0;
            rd_slot  = 0;
            held     = 0;
            wr_off   = 0;
            rd_off   = 0;
            too_long = 1'b0;
            blocked  = 1'b0;
        endfunction

        function int unsigned used_slots();
            int unsigned n;
            n = slot_count;
            if (n == 0)
                n = 1;
            if (n > SLOTS)
                n = SLOTS;
            return n;
        endfunction

        function int unsigned frame_limit();
            return (max_frame > SLOT_BYTES) ? SLOT_BYTES : max_frame;
        endfunction

        function int unsigned advance(int unsigned s);
            return (s + 1 >= used_slots()) ? 0 : s + 1;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_SLOT_COUNT)
                slot_count = data[SCOUNT_W-1:0];
            else if (idx == CFG_MAX_FRAME)
                max_frame = data[MAXLEN_W-1:0];
        endfunction

        // a read must never land on a slot whose length was never stored
        function bit read_defined();
            return (held == 0) || len_written[rd_slot % SLOTS];
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_word(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] data, logic last);
            ring_result_t r;
            bit           full;
            r = '0;
            r.status = STAT_OK;
            case (kind)
                KIND_WRITE:
                begin
                    full = (held >= used_slots());
                    if (wr_off >= frame_limit())
                        too_long = 1'b1;
                    else
                    begin
                        if (full)
                            blocked = 1'b1;
                        else
                            byte_store[(wr_slot % SLOTS) * SLOT_BYTES + wr_off % SLOT_BYTES] = data;
                        wr_off++;
                    end
                    if (last)
                    begin
                        if (full || blocked)
                            r.status = STAT_FULL;
                        else if (too_long)
                            r.status = STAT_TOO_LONG;
                        else
                        begin
                            frame_len[wr_slot % SLOTS]   = wr_off;
                            len_written[wr_slot % SLOTS] = 1'b1;
                            wr_slot = advance(wr_slot);
                            held++;
                        end
                        wr_off   = 0;
                        too_long = 1'b0;
                        blocked  = 1'b0;
                    end
                end
                KIND_READ:
                begin
                    if (held == 0)
                        r.status = STAT_EMPTY;
                    else
                    begin
                        r.rd_byte = byte_store[(rd_slot % SLOTS) * SLOT_BYTES + rd_off % SLOT_BYTES];
                        if (rd_off + 1 >= frame_len[rd_slot % SLOTS])
                        begin
                            r.rd_last = 1'b1;
                            rd_off    = 0;
                            rd_slot   = advance(rd_slot);
                            held--;
                        end
                        else
                            rd_off++;
                    end
                end
                KIND_FLUSH:
                    clear_ring();
                default:
                    ;
            endcase
            r.frame_count = held[CNT_W-1:0];
            pending_results.push_back(r);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_word(ring_result_t got);
            ring_result_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected result status=%0d byte=%02h last=%0d count=%0d",
                                 got.status, got.rd_byte, got.rd_last, got.frame_count));
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
                report($sformatf("status=%0d, predicted %0d", got.status, want.status));
            if (got.rd_byte !== want.rd_byte)
                report($sformatf("rd_byte=%02h, predicted %02h", got.rd_byte, want.rd_byte));
            if (got.rd_last !== want.rd_last)
                report($sformatf("rd_last=%0d, predicted %0d", got.rd_last, want.rd_last));
            if (got.frame_count !== want.frame_count)
                report($sformatf("frame_count=%0d, predicted %0d",
                                 got.frame_count, want.frame_count));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [7:0] wr_byte
    logic                  s_tlast;   // wr_last
    logic [1:0]            s_tuser;   // [1:0] kind
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;   // [7:0] rd_byte, [14:8] frame_count
    logic                  m_tlast;   // rd_last
    logic [1:0]            m_tuser;   // [1:0] status
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    frame_ring_scoreboard sb = new();
    bit                   src_burst;   // source sends back to back while set
    bit                   snk_burst;   // sink never stalls while set
    int                   cycles;

    frame_slot_ring_fifo_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #CLK_LOW clk = 1'b1;
        #CLK_HIGH clk = 1'b0;
    end

    // Watchdog: a stuck handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Offer one word after a random gap and hold it until the block takes it.
    // Valid stays high into the next word when that word has no gap.
    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] data,
                             input logic last);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  = kind;
        s_tdata  = data;
        s_tlast  = last;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        sb.note_word(kind, data, last);
    endtask

    // Read one byte with junk in the unused fields; turn it into a flush where the
    // read would hit a slot that never held a committed length.
    task automatic send_read();
        if (sb.read_defined())
            send_word(KIND_READ, 8'($urandom), 1'($urandom));
        else
            send_word(KIND_FLUSH, 8'($urandom), 1'($urandom));
    endtask

    task automatic send_frame(input int unsigned len, input bit with_reads);
        for (int unsigned i = 0; i < len; i++)
        begin
            if (with_reads && $urandom_range(0, 9) == 0)
                send_read();
            send_word(KIND_WRITE, 8'($urandom), (i == len - 1));
        end
    endtask

    // Drop valid, wait for every predicted result, then let the pipeline empty.
    task automatic settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_config(input int slots, input int maxlen);
        settle();
        cfg_write(CFG_SLOT_COUNT, CFG_DATA_W'(slots));
        cfg_write(CFG_MAX_FRAME, CFG_DATA_W'(maxlen));
    endtask

    // Result sink: stall for a random gap before each word, then check it.
    initial
    begin
        ring_result_t got;
        int           gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = snk_burst ? 0 : $urandom_range(0, MAX_GAP);
            @(negedge clk);
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got.status      = m_tuser;
            got.rd_byte     = m_tdata[7:0];
            got.rd_last     = m_tlast;
            got.frame_count = m_tdata[14:8];
            sb.check_word(got);
        end
    end

    initial
    begin
        int          slots, maxlen, words, pick, len, cap;
        int unsigned room;
        cycles    = 0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        s_tuser   = KIND_WRITE;
        cfg_valid = 1'b0;
        cfg_index = CFG_SLOT_COUNT;
        cfg_data  = '0;
        src_burst = 1'b0;
        snk_burst = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: default config, empty read, spare kind, extreme bytes, flush
        send_word(KIND_READ, 8'h00, 1'b0);
        send_word(KIND_SPARE, 8'hFF, 1'b1);
        send_word(KIND_WRITE, 8'h00, 1'b0);
        send_word(KIND_WRITE, 8'hFF, 1'b1);
        send_word(KIND_READ, 8'hFF, 1'b1);
        send_word(KIND_READ, 8'h00, 1'b0);
        send_word(KIND_FLUSH, 8'h5A, 1'b0);

        // One slot, two-byte frames: the ring is full after a single commit
        apply_config(1, 2);
        send_word(KIND_WRITE, 8'hA5, 1'b1);
        // byte arrives while full; the read frees the slot but the frame still drops
        send_word(KIND_WRITE, 8'h3C, 1'b0);
        send_word(KIND_READ, 8'h00, 1'b0);
        send_word(KIND_WRITE, 8'hC3, 1'b1);
        // one byte past the maximum
        send_frame(3, 1'b0);
        send_word(KIND_WRITE, 8'h44, 1'b1);
        // full and too long at once: full wins
        send_frame(3, 1'b0);
        send_word(KIND_READ, 8'h00, 1'b0);
        // flush abandons the partial frame; the next byte starts afresh
        send_word(KIND_WRITE, 8'h88, 1'b0);
        send_word(KIND_FLUSH, 8'h00, 1'b1);
        send_word(KIND_WRITE, 8'h99, 1'b1);
        send_word(KIND_READ, 8'h00, 1'b0);

        // Random phases; the ring is not flushed between them, so a change of the
        // slot count also lands while frames are held
        for (int p = 0; p < PHASES; p++)
        begin
            slots  = (slot_plan[p] < 0) ? $urandom_range(0, 127) : slot_plan[p];
            maxlen = (limit_plan[p] < 0) ? $urandom_range(0, 4095) : limit_plan[p];
            apply_config(slots, maxlen);
            src_burst = ($urandom_range(0, 3) == 0);
            snk_burst = ($urandom_range(0, 3) == 0);
            words = 0;

            // with every slot in use, fill the ring and run past it
            if (sb.used_slots() == SLOTS)
            begin
                room = SLOTS + 2;
                for (int unsigned i = 0; i < room; i++)
                    send_word(KIND_WRITE, 8'($urandom), 1'b1);
                words += room;
            end

            while (words < PHASE_WORDS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    // mostly short frames, now and then up to just past the limit
                    cap = sb.frame_limit() + 2;
                    if (cap > 40)
                        cap = 40;
                    len = ($urandom_range(0, 6) == 0) ? $urandom_range(1, cap)
                                                      : $urandom_range(1, 6);
                    send_frame(len, 1'b1);
                    words += len;
                end
                else if (pick < 85)
                begin
                    len = $urandom_range(1, 10);
                    repeat (len) send_read();
                    words += len;
                end
                else if (pick < 90)
                begin
                    send_word(KIND_FLUSH, 8'($urandom), 1'($urandom));
                    words++;
                end
                else if (pick < 94)
                begin
                    send_word(KIND_SPARE, 8'($urandom), 1'($urandom));
                    words++;
                end
                else
                begin
                    // stray byte, possibly closing a frame that is not there
                    send_word(KIND_WRITE, 8'($urandom), 1'($urandom));
                    words++;
                end
            end
        end

        // Long frames, back to back from an empty ring: one just too long, one at the limit
        apply_config(4, LONG_FRAME);
        src_burst = 1'b1;
        snk_burst = 1'b1;
        send_word(KIND_FLUSH, 8'h00, 1'b0);
        send_frame(LONG_FRAME + 1, 1'b0);
        send_frame(LONG_FRAME, 1'b0);
        send_frame(1, 1'b0);
        while (sb.held > 0)
            send_read();

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
